[sv/csfw_pkg.sv]
`timescale 1ns / 1ps
// Package for the counting semaphore with FIFO wait queue.
// Holds result codes, count limits and parameter defaults; no dependencies.
package csfw_pkg;

  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int ID_BITS_DEF       = 8;
  localparam int PRIORITY_BITS_DEF = 8;

  localparam int INIT_W  = 15;
  localparam int COUNT_W = 16;
  localparam int COUNT_MAX = 32767;

  typedef enum logic [2:0] {
    ACT_PROCEED = 3'd0,
    ACT_BLOCK   = 3'd1,
    ACT_WOKEN   = 3'd2,
    ACT_YIELD   = 3'd3,
    ACT_ERROR   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_FULL = 2'd1,
    ERR_SAT  = 2'd2
  } err_t;

  localparam logic OP_WAIT   = 1'b0;
  localparam logic OP_SIGNAL = 1'b1;

endpackage

[sv/counting_semaphore_fifo_waiters_core.sv]
`timescale 1ns / 1ps
// Counting semaphore with a FIFO wait queue held in a synchronous-read RAM.
// The result is registered in the cycle after accept; a signal that wakes first passes through ST_READ.
// Throughput: one item per cycle for waits and non-waking signals while the result channel is not stalled;
// a waking signal holds the input through ST_READ, set by the synchronous read of the waiter RAM at the queue head.
// Reset (rst_n low, synchronous): count and queue pointers to zero, output empty.
// Depends on csfw_pkg.
module counting_semaphore_fifo_waiters_core
  import csfw_pkg::*;
#(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int ID_BITS       = ID_BITS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration: initial count
  input  logic                      cfg_we,
  input  logic [INIT_W-1:0]         cfg_initial_count,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_opcode,
  input  logic [ID_BITS-1:0]        in_caller_id,
  input  logic [PRIORITY_BITS-1:0]  in_caller_priority,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                out_action,
  output logic [ID_BITS-1:0]        out_woken_id,
  output logic [1:0]                out_error_kind,
  output logic signed [COUNT_W-1:0] out_count_after
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int ENT_W = ID_BITS + PRIORITY_BITS;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  // Lowest count allowed: one negative step per queued waiter.
  localparam logic signed [COUNT_W-1:0] COUNT_FLOOR = COUNT_W'(-QUEUE_DEPTH);
  localparam logic signed [COUNT_W-1:0] COUNT_TOP   = COUNT_W'(COUNT_MAX);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // ---------------------------------------------------------------------------
  // Waiter RAM: {priority, id}, written at the tail, read at the head.
  // ---------------------------------------------------------------------------
  logic [ENT_W-1:0] wq_mem [QUEUE_DEPTH];
  logic [ENT_W-1:0] rd_data_r;
  logic             mem_we;
  logic             mem_re;

  // ---------------------------------------------------------------------------
  // Control and datapath state
  // ---------------------------------------------------------------------------
  state_t                      state_r, state_nxt;
  logic signed [COUNT_W-1:0]   count_r, count_nxt;
  logic [PTR_W-1:0]            head_r, head_nxt;
  logic [PTR_W-1:0]            tail_r, tail_nxt;
  logic [PRIORITY_BITS-1:0]    sig_pri_r;

  logic                        out_valid_r, out_valid_nxt;
  action_t                     out_action_r, out_action_nxt;
  logic [ID_BITS-1:0]          out_woken_r, out_woken_nxt;
  err_t                        out_err_r, out_err_nxt;
  logic signed [COUNT_W-1:0]   out_count_r, out_count_nxt;

  logic out_fire;
  logic out_free;
  logic accept;
  logic q_full;
  logic cnt_sat;
  logic wake;

  assign out_fire = out_valid_r & ~out_stall;
  // Output slot can take a new result this edge.
  assign out_free = ~out_valid_r | ~out_stall;
  // One request at a time; a waking signal holds the input during its RAM read.
  assign in_stall = (state_r != ST_IDLE) | ~out_free;
  assign accept   = in_valid & ~in_stall;

  assign q_full  = (count_r <= COUNT_FLOOR);
  assign cnt_sat = (count_r >= COUNT_TOP);
  // A signal with a negative count always dequeues; saturation cannot apply there.
  assign wake    = accept & (in_opcode == OP_SIGNAL) & (count_r < 0);

  // Wait that drives the count negative enqueues at the tail.
  assign mem_we = accept & (in_opcode == OP_WAIT) & ~q_full & (count_r <= 0);
  assign mem_re = wake;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wq_mem[tail_r] <= {in_caller_priority, in_caller_id};
    end
    if (mem_re) begin
      rd_data_r <= wq_mem[head_r];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    out_valid_nxt  = out_valid_r & ~out_fire;
    out_action_nxt = out_action_r;
    out_woken_nxt  = out_woken_r;
    out_err_nxt    = out_err_r;
    out_count_nxt  = out_count_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_woken_nxt  = '0;
          out_err_nxt    = ERR_NONE;
          out_action_nxt = ACT_PROCEED;
          if (in_opcode == OP_WAIT) begin
            if (q_full) begin
              out_action_nxt = ACT_ERROR;
              out_err_nxt    = ERR_FULL;
            end else begin
              count_nxt = count_r - COUNT_W'(1);
              if (count_r <= 0) begin
                out_action_nxt = ACT_BLOCK;
                tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
              end
            end
          end else begin
            if (cnt_sat) begin
              out_action_nxt = ACT_ERROR;
              out_err_nxt    = ERR_SAT;
            end else begin
              count_nxt = count_r + COUNT_W'(1);
              if (count_r < 0) begin
                head_nxt = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
              end
            end
          end
          out_count_nxt = count_nxt;
          if (wake) begin
            // result waits for the head entry
            state_nxt = ST_READ;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_READ: begin
        // Output slot is empty here: it was free when the signal was taken.
        out_valid_nxt  = 1'b1;
        out_woken_nxt  = rd_data_r[ID_BITS-1:0];
        out_action_nxt = (sig_pri_r < rd_data_r[ENT_W-1:ID_BITS]) ? ACT_YIELD : ACT_WOKEN;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Loading the initial count drops every queued waiter.
    if (cfg_we) begin
      count_nxt = COUNT_W'(cfg_initial_count);
      head_nxt  = '0;
      tail_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (accept) begin
      sig_pri_r <= in_caller_priority;
    end
    out_action_r <= out_action_nxt;
    out_woken_r  <= out_woken_nxt;
    out_err_r    <= out_err_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_action      = out_action_r;
  assign out_woken_id    = out_woken_r;
  assign out_error_kind  = out_err_r;
  assign out_count_after = out_count_r;

endmodule

[dv/tb_counting_semaphore_fifo_waiters_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for counting_semaphore_fifo_waiters_core: queue-fed driver,
// clocked monitor, in-bench semaphore predictor. Depends on csfw_pkg and the core RTL.
module tb_counting_semaphore_fifo_waiters_core
  import csfw_pkg::*;
();

  localparam int QDEPTH      = QUEUE_DEPTH_DEF;
  localparam int ID_W        = ID_BITS_DEF;
  localparam int PRI_W       = PRIORITY_BITS_DEF;
  // Far above the slowest legal run: ~1150 items, waking signals held for the RAM read,
  // plus random gaps and stalls on both sides.
  localparam int CYCLE_LIMIT = 200000;

  // One request as the sender presents it.
  typedef struct packed {
    logic             op;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } sem_req_t;

  // One predicted result.
  typedef struct packed {
    action_t                   act;
    logic [ID_W-1:0]           woken;
    err_t                      err;
    logic signed [COUNT_W-1:0] count;
  } sem_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [INIT_W-1:0]         cfg_initial_count;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_opcode;
  logic [ID_W-1:0]           in_caller_id;
  logic [PRI_W-1:0]          in_caller_priority;
  logic                      out_valid;
  logic                      out_stall;
  logic [2:0]                out_action;
  logic [ID_W-1:0]           out_woken_id;
  logic [1:0]                out_error_kind;
  logic signed [COUNT_W-1:0] out_count_after;

  counting_semaphore_fifo_waiters_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_initial_count  (cfg_initial_count),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_caller_id       (in_caller_id),
    .in_caller_priority (in_caller_priority),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_action         (out_action),
    .out_woken_id       (out_woken_id),
    .out_error_kind     (out_error_kind),
    .out_count_after    (out_count_after)
  );

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Stimulus and expectation stores
  sem_req_t    request_backlog[$];   // requests not yet presented
  sem_result_t sem_results_due[$];   // predicted results, oldest first
  logic        req_busy;             // a request is on the bus, not yet taken
  logic        hold_off;             // sender paused on purpose
  int unsigned idle_pct;             // sender gap / receiver stall odds, percent

  // Predictor state: count and the circular waiter queue
  int               sem_level;
  logic [ID_W-1:0]  waiter_id  [QDEPTH];
  logic [PRI_W-1:0] waiter_pri [QDEPTH];
  int               q_head;
  int               q_tail;

  // Bookkeeping
  int fails;
  int cycles;
  int n_results;
  int n_blocked;
  int n_woken;
  int n_yield;
  int n_full;
  int n_sat;
  int n_loads;

  task automatic report_mismatch(input string field, input int got, input int want);
    fails++;
    $display("[%0t] result %0d: %s got %0d expected %0d", $time, n_results, field, got, want);
  endtask

  // Apply one request to the predicted semaphore and queue the result it must produce.
  task automatic step_semaphore(input sem_req_t rq);
    sem_result_t r;
    r.act   = ACT_PROCEED;
    r.woken = '0;
    r.err   = ERR_NONE;
    if (rq.op == OP_WAIT) begin
      if (sem_level <= -QDEPTH) begin
        // queue full: nothing changes
        r.act = ACT_ERROR;
        r.err = ERR_FULL;
      end else begin
        sem_level--;
        if (sem_level < 0) begin
          waiter_id[q_tail]  = rq.id;
          waiter_pri[q_tail] = rq.pri;
          q_tail             = (q_tail + 1) % QDEPTH;
          r.act              = ACT_BLOCK;
        end
      end
    end else begin
      if (sem_level >= COUNT_MAX) begin
        // saturated: nothing changes
        r.act = ACT_ERROR;
        r.err = ERR_SAT;
      end else begin
        if (sem_level < 0) begin
          // oldest waiter leaves; yield only if strictly higher priority
          r.woken = waiter_id[q_head];
          r.act   = (rq.pri < waiter_pri[q_head]) ? ACT_YIELD : ACT_WOKEN;
          q_head  = (q_head + 1) % QDEPTH;
        end
        sem_level++;
      end
    end
    r.count = COUNT_W'(sem_level);
    sem_results_due.push_back(r);
  endtask

  // Rising edge: check the result leaving the block first, then take the
  // request entering it, so predictions follow acceptance order.
  always @(posedge clk) begin
    sem_result_t due;
    sem_req_t    rq;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               sem_results_due.size());
      $display("** counting_semaphore_fifo_waiters_core: FAILED **");
      $finish;
    end else if (!rst_n) begin
      sem_level = 0;
      q_head    = 0;
      q_tail    = 0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (sem_results_due.size() == 0) begin
          fails++;
          $display("[%0t] result with nothing expected: action %0d count %0d", $time,
                   out_action, out_count_after);
        end else begin
          due = sem_results_due.pop_front();
          if (out_action !== due.act)
            report_mismatch("action", out_action, due.act);
          if (out_woken_id !== due.woken)
            report_mismatch("woken_id", out_woken_id, due.woken);
          if (out_error_kind !== due.err)
            report_mismatch("error_kind", out_error_kind, due.err);
          if (out_count_after !== due.count)
            report_mismatch("count_after", out_count_after, due.count);
          case (due.act)
            ACT_BLOCK: n_blocked++;
            ACT_WOKEN: n_woken++;
            ACT_YIELD: n_yield++;
            ACT_ERROR: begin
              if (due.err == ERR_FULL) n_full++;
              else n_sat++;
            end
            default: ;
          endcase
        end
        n_results++;
      end
      // a register write reloads the count and drops all waiters
      if (cfg_we) begin
        sem_level = int'(cfg_initial_count);
        q_head    = 0;
        q_tail    = 0;
        n_loads++;
      end
      if (in_valid && in_stall === 1'b0) begin
        rq.op  = in_opcode;
        rq.id  = in_caller_id;
        rq.pri = in_caller_priority;
        step_semaphore(rq);
        req_busy = 1'b0;
      end
    end
  end

  // Driver: a new item goes out only once the previous one was taken;
  // a stalled item is left untouched.
  always @(negedge clk) begin
    sem_req_t rq;
    if (rst_n && !req_busy) begin
      if (hold_off || request_backlog.size() == 0 || $urandom_range(99) < idle_pct) begin
        in_valid <= 1'b0;
      end else begin
        rq = request_backlog.pop_front();
        in_opcode          <= rq.op;
        in_caller_id       <= rq.id;
        in_caller_priority <= rq.pri;
        in_valid           <= 1'b1;
        req_busy = 1'b1;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  task automatic push_req(input logic op, input int id, input int pri);
    sem_req_t rq;
    rq.op  = op;
    rq.id  = ID_W'(id);
    rq.pri = PRI_W'(pri);
    request_backlog.push_back(rq);
  endtask

  // Block until every item is taken and every result is back, plus a margin
  // for the waking path through the RAM read.
  task automatic wait_drained();
    while (request_backlog.size() != 0 || req_busy || sem_results_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_initial_count(input int value);
    wait_drained();
    @(negedge clk);
    cfg_we            <= 1'b1;
    cfg_initial_count <= INIT_W'(value);
    @(negedge clk);
    cfg_we            <= 1'b0;
  endtask

  // Runs of waits and runs of signals push the count deep into the queue and
  // back out again; some runs are plain mixed noise. Priorities often come from
  // a tiny set so equal-priority wakes show up.
  task automatic queue_traffic(input int n_items, input int sig_pct);
    int   run_len;
    logic run_op;
    logic mixed;
    int   pri;
    int   k;
    k = 0;
    while (k < n_items) begin
      run_len = $urandom_range(1, 20);
      run_op  = ($urandom_range(99) < sig_pct) ? OP_SIGNAL : OP_WAIT;
      mixed   = ($urandom_range(4) == 0);
      for (int j = 0; j < run_len && k < n_items; j++) begin
        pri = ($urandom_range(99) < 30) ? $urandom_range(0, 3) : $urandom_range(0, 255);
        if (mixed)
          push_req(1'($urandom_range(1)), $urandom_range(0, 255), pri);
        else
          push_req(run_op, $urandom_range(0, 255), pri);
        k++;
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_initial_count  = '0;
    in_valid           = 1'b0;
    in_opcode          = OP_WAIT;
    in_caller_id       = '0;
    in_caller_priority = '0;
    out_stall          = 1'b0;
    req_busy           = 1'b0;
    hold_off           = 1'b0;
    idle_pct           = 24;
    fails              = 0;
    cycles             = 0;
    n_results          = 0;
    n_blocked          = 0;
    n_woken            = 0;
    n_yield            = 0;
    n_full             = 0;
    n_sat              = 0;
    n_loads            = 0;
    sem_level          = 0;
    q_head             = 0;
    q_tail             = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: count from reset is zero
    push_req(OP_SIGNAL, 0, 0);        // proceed, count 1
    push_req(OP_WAIT, 255, 255);      // proceed, count 0
    // fill the wait queue, then one more wait hits queue full
    push_req(OP_WAIT, 17, 100);
    push_req(OP_WAIT, 34, 100);
    push_req(OP_WAIT, 0, 0);
    push_req(OP_WAIT, 255, 255);
    for (int i = 4; i < QDEPTH; i++)
      push_req(OP_WAIT, $urandom_range(0, 255), $urandom_range(0, 255));
    push_req(OP_WAIT, 200, 200);      // queue full
    push_req(OP_SIGNAL, 1, 100);      // equal priority: plain wake
    push_req(OP_SIGNAL, 2, 99);       // waiter higher: yield
    push_req(OP_SIGNAL, 3, 255);      // waiter at 0: plain wake
    push_req(OP_SIGNAL, 4, 0);        // waiter at 255 vs 0: yield

    // Directed: top of the count range
    load_initial_count(COUNT_MAX);
    push_req(OP_SIGNAL, 9, 9);        // saturated
    push_req(OP_WAIT, 10, 10);
    push_req(OP_SIGNAL, 11, 11);
    push_req(OP_SIGNAL, 12, 12);      // saturated again

    // Random traffic under several loads of the register
    load_initial_count(0);
    queue_traffic(200, 50);
    // pause the sender mid-phase until every result is back
    while (request_backlog.size() > 100) @(posedge clk);
    hold_off = 1'b1;
    while (req_busy || sem_results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    hold_off = 1'b0;

    load_initial_count(2);
    idle_pct = 0;                     // back-to-back stretch, no gaps or stalls
    queue_traffic(200, 50);
    wait_drained();
    idle_pct = 24;

    load_initial_count($urandom_range(0, 20));
    queue_traffic(200, 40);           // leans toward a full queue

    load_initial_count(COUNT_MAX - 7);
    queue_traffic(150, 65);           // leans toward saturation

    load_initial_count($urandom_range(0, COUNT_MAX));
    queue_traffic(150, 50);

    load_initial_count(1);
    queue_traffic(200, 50);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("checked %0d results over %0d register loads: %0d blocked, %0d woken, %0d yields",
             n_results, n_loads, n_blocked, n_woken, n_yield);
    $display("errors answered: %0d queue full, %0d count saturated; %0d mismatches",
             n_full, n_sat, fails);
    if (fails == 0) begin
      $display("** counting_semaphore_fifo_waiters_core: PASSED **");
    end else begin
      $display("** counting_semaphore_fifo_waiters_core: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/csfw_pkg.sv
sv/counting_semaphore_fifo_waiters_core.sv
dv/tb_counting_semaphore_fifo_waiters_core.sv
